/* rtl/pulse_train_replay_generator_core_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the pulse train replay generator
// Clocked on aclk; the checked form is left out of synthesis.
// -----------------------------------------------------------------------------
`ifndef PULSE_TRAIN_REPLAY_GENERATOR_CORE_ASSERT_SVH
`define PULSE_TRAIN_REPLAY_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define PTRG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// property checked during reset as well
`define PTRG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define PTRG_ASSERT(label, prop, msg)
`define PTRG_ASSERT_RST(label, prop, msg)
`endif

`endif

/* rtl/ptrg_pkg.sv */
// -----------------------------------------------------------------------------
// ptrg_pkg
// Shared types, constants and helpers of the pulse train replay generator.
// -----------------------------------------------------------------------------
package ptrg_pkg;

    localparam int unsigned NUM_CODES_DEF        = 4;
    localparam int unsigned ENTRIES_PER_CODE_DEF = 132;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CODE_W8  = 8;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned WIDTH_W  = 16;
    localparam int unsigned REPEAT_W = 8;
    localparam int unsigned GAP_W    = 16;

    localparam logic [15:0] REPEAT_COUNT_RST = 16'd10;
    localparam logic [15:0] GAP_TICKS_RST    = 16'd9300;

    // APB register map
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic REG_REPEAT_COUNT = 1'b0;
    localparam logic REG_GAP_TICKS    = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_START = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MARK,
        PH_SPACE,
        PH_GAP
    } phase_t;

    typedef struct packed {
        mode_t               mode;
        logic [CODE_W8-1:0]  code_select;
        logic [INDEX_W-1:0]  entry_index;
        logic [WIDTH_W-1:0]  entry_width;
    } item_t;

    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic tx_level;
    } result_t;

    // a zero width still lasts one tick
    function automatic logic [WIDTH_W-1:0] stretch(input logic [WIDTH_W-1:0] w);
        return (w == '0) ? WIDTH_W'(1) : w;
    endfunction

endpackage

/* rtl/ptrg_table.sv */
// -----------------------------------------------------------------------------
// ptrg_table
// Pulse width store: one write port, one registered read port.
// -----------------------------------------------------------------------------
module ptrg_table #(
    parameter int unsigned NUM_CODES        = ptrg_pkg::NUM_CODES_DEF,
    parameter int unsigned ENTRIES_PER_CODE = ptrg_pkg::ENTRIES_PER_CODE_DEF
) (
    input  logic                                              aclk,
    input  logic                                              wr_en,
    input  logic [$clog2(NUM_CODES*ENTRIES_PER_CODE)-1:0]     wr_addr,
    input  logic [ptrg_pkg::WIDTH_W-1:0]                      wr_data,
    input  logic [$clog2(NUM_CODES*ENTRIES_PER_CODE)-1:0]     rd_addr,
    output logic [ptrg_pkg::WIDTH_W-1:0]                      rd_data
);
    import ptrg_pkg::*;

    localparam int unsigned DEPTH = NUM_CODES * ENTRIES_PER_CODE;

    logic [WIDTH_W-1:0] mem [DEPTH];
    logic [WIDTH_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ptrg_seq.sv */
// -----------------------------------------------------------------------------
// ptrg_seq
// Train sequencer: command decode, phase/position/countdown state.
// -----------------------------------------------------------------------------
module ptrg_seq #(
    parameter int unsigned NUM_CODES        = ptrg_pkg::NUM_CODES_DEF,
    parameter int unsigned ENTRIES_PER_CODE = ptrg_pkg::ENTRIES_PER_CODE_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              item_valid,
    input  ptrg_pkg::item_t                                   item,
    input  logic [ptrg_pkg::REPEAT_W-1:0]                     repeat_count,
    input  logic [ptrg_pkg::GAP_W-1:0]                        gap_ticks,
    input  logic [ptrg_pkg::WIDTH_W-1:0]                      rd_data,
    output logic [$clog2(NUM_CODES*ENTRIES_PER_CODE)-1:0]     rd_addr,
    output logic                                              wr_en,
    output logic [$clog2(NUM_CODES*ENTRIES_PER_CODE)-1:0]     wr_addr,
    output logic [ptrg_pkg::WIDTH_W-1:0]                      wr_data,
    output ptrg_pkg::result_t                                 result
);
    import ptrg_pkg::*;

    localparam int unsigned CODE_W = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
    localparam int unsigned POS_W  = $clog2(ENTRIES_PER_CODE);
    localparam int unsigned ADDR_W = $clog2(NUM_CODES * ENTRIES_PER_CODE);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'((ENTRIES_PER_CODE / 2) * 2 - 1);
    localparam logic [8:0] NUM_CODES_9 = 9'(NUM_CODES);
    localparam logic [8:0] ENTRIES_9   = 9'(ENTRIES_PER_CODE);

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [WIDTH_W-1:0]  cnt_reg, cnt_next;
    logic                fresh_reg, fresh_next;   // countdown still sits in rd_data
    logic [REPEAT_W-1:0] reps_reg, reps_next;
    logic [CODE_W-1:0]   code_reg, code_next;

    logic                rej;
    logic                busy;
    logic                code_ok;
    logic                idx_ok;
    logic [WIDTH_W-1:0]  ticks_now;

    assign busy      = (phase_reg != PH_IDLE);
    assign code_ok   = ({1'b0, item.code_select} < NUM_CODES_9);
    assign idx_ok    = ({1'b0, item.entry_index} < ENTRIES_9);
    assign ticks_now = fresh_reg ? stretch(rd_data) : cnt_reg;

    // next state
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        reps_next  = reps_reg;
        code_next  = code_reg;
        rej        = 1'b0;
        wr_en      = 1'b0;
        if (item_valid) begin
            unique case (item.mode)
                MODE_WRITE: begin
                    if (busy || !code_ok || !idx_ok) begin
                        rej = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
                MODE_START: begin
                    if (busy || !code_ok) begin
                        rej = 1'b1;
                    end else if (repeat_count != '0) begin
                        code_next  = item.code_select[CODE_W-1:0];
                        reps_next  = repeat_count;
                        phase_next = PH_MARK;
                        pos_next   = '0;
                        fresh_next = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (busy && ticks_now > WIDTH_W'(1)) begin
                        cnt_next   = ticks_now - WIDTH_W'(1);
                        fresh_next = 1'b0;
                    end else begin
                        unique case (phase_reg)
                            PH_IDLE: ;
                            PH_MARK: begin
                                pos_next   = pos_reg + POS_W'(1);
                                phase_next = PH_SPACE;
                                fresh_next = 1'b1;
                            end
                            PH_SPACE: begin
                                if (pos_reg == LAST_POS) begin
                                    phase_next = PH_GAP;
                                    cnt_next   = stretch(gap_ticks);
                                    fresh_next = 1'b0;
                                end else begin
                                    pos_next   = pos_reg + POS_W'(1);
                                    phase_next = PH_MARK;
                                    fresh_next = 1'b1;
                                end
                            end
                            PH_GAP: begin
                                reps_next = reps_reg - REPEAT_W'(1);
                                pos_next  = '0;
                                if (reps_reg == REPEAT_W'(1)) begin
                                    phase_next = PH_IDLE;
                                    cnt_next   = '0;
                                    fresh_next = 1'b0;
                                end else begin
                                    phase_next = PH_MARK;
                                    fresh_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                MODE_NONE: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        result.tx_level = (phase_next == PH_MARK);
        result.busy_res = (phase_next != PH_IDLE);
        result.rejected = rej;
    end

    // read address follows the word in use; data lands for the next cycle
    assign rd_addr = ADDR_W'(code_next) * ADDR_W'(ENTRIES_PER_CODE) + ADDR_W'(pos_next);
    assign wr_addr = ADDR_W'(item.code_select[CODE_W-1:0]) * ADDR_W'(ENTRIES_PER_CODE)
                   + ADDR_W'(item.entry_index[POS_W-1:0]);
    assign wr_data = item.entry_width;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            fresh_reg <= 1'b0;
            reps_reg  <= '0;
            code_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            reps_reg  <= reps_next;
            code_reg  <= code_next;
        end
    end

endmodule

/* rtl/pulse_train_replay_generator_core.sv */
// -----------------------------------------------------------------------------
// pulse_train_replay_generator_core
// Replays stored on-off keyed pulse trains on one transmit line.
// -----------------------------------------------------------------------------
// Each input item is a table write, a start or a one-microsecond tick (s_tuser).
// Every item yields exactly one result item carrying the line level after the
// item, the busy flag and a rejected flag. Items go through an input register,
// one pass of decode/sequencer logic and a result register, so one item per
// clock is sustained while m_tready is high. While a result waits on m_tready
// the input register can still take one more item; once it holds that item,
// s_tready stays low until the result is taken. Reads follow the next state, so
// the next width is ready in the read port and back-to-back ticks on one-tick
// pulses run at full rate. Writes and starts are refused while a train
// (including its final gap) is running, or for codes out of range; writes also
// for indices out of range. The width table has no reset; sending a word never
// written gives an undefined width. No clearing pass is needed after reset.
// -----------------------------------------------------------------------------
module pulse_train_replay_generator_core #(
    parameter int unsigned NUM_CODES        = ptrg_pkg::NUM_CODES_DEF,
    parameter int unsigned ENTRIES_PER_CODE = ptrg_pkg::ENTRIES_PER_CODE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input item channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // code_select[7:0], entry_index[15:8],
                                                    // entry_width[31:16]
    input  logic [ptrg_pkg::MODE_W-1:0]   s_tuser,  // mode[1:0]
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // tx_level[0], busy_res[1], rejected[2],
                                                    // zero[7:3]
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptrg_pkg::PADDR_W-1:0]  paddr,
    input  logic [ptrg_pkg::PDATA_W-1:0]  pwdata,
    output logic [ptrg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ptrg_pkg::*;

    `include "pulse_train_replay_generator_core_assert.svh"

    localparam int unsigned ADDR_W = $clog2(NUM_CODES * ENTRIES_PER_CODE);

    // ---- configuration registers ----
    logic [REPEAT_W-1:0] repeat_count_reg;
    logic [GAP_W-1:0]    gap_ticks_reg;
    logic                cfg_wr;
    logic                cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_count_reg <= REPEAT_COUNT_RST[REPEAT_W-1:0];
            gap_ticks_reg    <= GAP_TICKS_RST;
        end else if (cfg_wr) begin
            if (cfg_sel == REG_REPEAT_COUNT) begin
                repeat_count_reg <= pwdata[REPEAT_W-1:0];
            end else begin
                gap_ticks_reg <= pwdata[GAP_W-1:0];
            end
        end
    end

    assign prdata = (cfg_sel == REG_GAP_TICKS)
                  ? {{(PDATA_W-GAP_W){1'b0}}, gap_ticks_reg}
                  : {{(PDATA_W-REPEAT_W){1'b0}}, repeat_count_reg};

    // ---- input register ----
    logic  in_valid_reg;
    item_t in_item_reg;
    logic  advance;     // input item moves into the result register

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.mode        <= mode_t'(s_tuser);
            in_item_reg.code_select <= s_tdata[7:0];
            in_item_reg.entry_index <= s_tdata[15:8];
            in_item_reg.entry_width <= s_tdata[31:16];
        end
    end

    // ---- sequencer and width table ----
    logic                tbl_wr_en;
    logic [ADDR_W-1:0]   tbl_wr_addr;
    logic [WIDTH_W-1:0]  tbl_wr_data;
    logic [ADDR_W-1:0]   tbl_rd_addr;
    logic [WIDTH_W-1:0]  tbl_rd_data;
    result_t             seq_result;

    ptrg_seq #(
        .NUM_CODES        (NUM_CODES),
        .ENTRIES_PER_CODE (ENTRIES_PER_CODE)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (advance),
        .item         (in_item_reg),
        .repeat_count (repeat_count_reg),
        .gap_ticks    (gap_ticks_reg),
        .rd_data      (tbl_rd_data),
        .rd_addr      (tbl_rd_addr),
        .wr_en        (tbl_wr_en),
        .wr_addr      (tbl_wr_addr),
        .wr_data      (tbl_wr_data),
        .result       (seq_result)
    );

    ptrg_table #(
        .NUM_CODES        (NUM_CODES),
        .ENTRIES_PER_CODE (ENTRIES_PER_CODE)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // ---- result register ----
    logic    out_valid_reg;
    result_t out_result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= seq_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.rejected, out_result_reg.busy_res,
                       out_result_reg.tx_level};

    // ---- checks ----
    `PTRG_ASSERT_RST(a_idle_after_reset, !aresetn |=> !m_tvalid,
        "result valid straight after reset")
    `PTRG_ASSERT(a_ready_when_room, (!m_tvalid || m_tready) |-> s_tready,
        "input stalled although the result side can move")
    `PTRG_ASSERT(a_tick_never_rejected, (advance && in_item_reg.mode == MODE_TICK) |=>
        !out_result_reg.rejected, "tick item flagged as rejected")
    `PTRG_ASSERT(a_line_low_when_idle, (m_tvalid && !out_result_reg.busy_res) |->
        !out_result_reg.tx_level, "line high while no train is running")

endmodule
